>>> hdl/swlf_pkg.sv
// Shared constants, register codes and types of the sync word length framer.
package swlf_pkg;

  localparam int unsigned SYNC_BITS_DEF   = 16;
  localparam int unsigned LENGTH_BITS_DEF = 8;

  localparam int unsigned SYNC_WORD_W = 16;
  localparam int unsigned BPU_W       = 8;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned CFG_IDX_W   = 1;

  localparam logic [SYNC_WORD_W-1:0] SYNC_WORD_RST = 16'hCCCC;
  localparam logic [BPU_W-1:0]       BPU_RST       = 8'd16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SYNC_WORD     = 1'b0,
    CFG_BITS_PER_UNIT = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic valid;
    logic data_bit;
    logic frame_end;
  } res_t;

endpackage

>>> hdl/swlf_in_if.sv
// Input channel carrying one received bit per beat.
interface swlf_in_if;
  logic valid;
  logic ready;
  logic bit_in;

  modport source (output valid, output bit_in, input ready);
  modport sink (input valid, input bit_in, output ready);
endinterface

>>> hdl/swlf_out_if.sv
// Output channel carrying one payload bit and its frame end flag per beat.
interface swlf_out_if;
  logic valid;
  logic ready;
  logic data_bit;
  logic frame_end;

  modport source (output valid, output data_bit, output frame_end, input ready);
  modport sink (input valid, input data_bit, input frame_end, output ready);
endinterface

>>> hdl/swlf_core.sv
// Framing state machine: sync hunt, length field capture and payload count.
module swlf_core #(
  parameter int unsigned SYNC_BITS   = swlf_pkg::SYNC_BITS_DEF,
  parameter int unsigned LENGTH_BITS = swlf_pkg::LENGTH_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             step_i,
  input  logic                             bit_i,
  input  logic [swlf_pkg::SYNC_WORD_W-1:0] sync_word_i,
  input  logic [swlf_pkg::BPU_W-1:0]       bits_per_unit_i,
  output swlf_pkg::res_t                   res_o
);

  localparam int unsigned FILL_W = $clog2(SYNC_BITS + 1);
  localparam int unsigned CNT_W  = LENGTH_BITS + swlf_pkg::BPU_W;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_LEN  = 2'd1,
    PH_DATA = 2'd2
  } phase_e;

  phase_e                 phase_q, phase_d;
  logic [SYNC_BITS-1:0]   window_q, window_d;
  logic [FILL_W-1:0]      fill_q, fill_d;
  logic [LENGTH_BITS-1:0] flen_q, flen_d;
  logic [CNT_W-1:0]       count_q, count_d;

  logic [SYNC_BITS+swlf_pkg::SYNC_WORD_W-1:0] sync_wide;
  logic [SYNC_BITS-1:0]   sync_cmp;
  logic [SYNC_BITS-1:0]   window_sh;
  logic [FILL_W-1:0]      fill_inc;
  logic [LENGTH_BITS:0]   flen_sh;
  logic [CNT_W-1:0]       count_inc;
  logic [CNT_W-1:0]       total;

  assign sync_wide = {{SYNC_BITS{1'b0}}, sync_word_i};
  assign sync_cmp  = sync_wide[SYNC_BITS-1:0];
  assign window_sh = {window_q[SYNC_BITS-2:0], bit_i};
  assign fill_inc  = (fill_q < FILL_W'(SYNC_BITS)) ? fill_q + FILL_W'(1) : fill_q;
  assign flen_sh   = {flen_q, bit_i};
  assign count_inc = count_q + CNT_W'(1);
  assign total     = CNT_W'(flen_q) * CNT_W'(bits_per_unit_i);

  always_comb begin
    phase_d  = phase_q;
    window_d = window_q;
    fill_d   = fill_q;
    flen_d   = flen_q;
    count_d  = count_q;
    res_o    = '0;
    unique case (phase_q)
      PH_LEN: begin
        flen_d  = flen_sh[LENGTH_BITS-1:0];
        count_d = count_inc;
        if (count_inc >= CNT_W'(LENGTH_BITS)) begin
          phase_d = PH_DATA;
          count_d = '0;
        end
      end
      PH_DATA: begin
        if (count_q < total) begin
          count_d         = count_inc;
          res_o.valid     = 1'b1;
          res_o.data_bit  = bit_i;
          res_o.frame_end = (count_inc == total);
        end else begin
          phase_d  = PH_HUNT;
          window_d = '0;
          fill_d   = '0;
          flen_d   = '0;
          count_d  = '0;
        end
      end
      default: begin
        phase_d  = PH_HUNT;
        window_d = window_sh;
        fill_d   = fill_inc;
        if (fill_inc >= FILL_W'(SYNC_BITS) && window_sh == sync_cmp) begin
          phase_d  = PH_LEN;
          window_d = '0;
          fill_d   = '0;
          flen_d   = '0;
          count_d  = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HUNT;
      window_q <= '0;
      fill_q   <= '0;
      flen_q   <= '0;
      count_q  <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      window_q <= window_d;
      fill_q   <= fill_d;
      flen_q   <= flen_d;
      count_q  <= count_d;
    end
  end

endmodule

>>> hdl/sync_word_length_framer_unit.sv
// Top level of the sync word length framer: channels, configuration and pipeline registers.
//
// The input channel takes one received bit per beat. The block hunts for the
// configured sync word, reads the length field that follows, and passes
// length times bits_per_unit payload bits to the output channel, one per beat,
// with frame_end set on the last one. The bit after the payload is dropped.
// A bit is held in an input register and is processed as it moves to the
// result register, which presents payload bits on the output.
// One beat can be accepted in every cycle unless the receiver stalls.
// Beats that produce no result leave the output untouched.
// When the receiver stalls, the result register holds its beat and the input
// register holds one more bit; input ready then drops until the output moves.
// Reset clears the framing state and both pipeline valid flags, and loads the
// configuration defaults (sync word 0xCCCC, 16 bits per unit). The user must write
// registers through the configuration port while no beat is in flight; it is not enforced.
module sync_word_length_framer_unit #(
  parameter int unsigned SYNC_BITS   = swlf_pkg::SYNC_BITS_DEF,
  parameter int unsigned LENGTH_BITS = swlf_pkg::LENGTH_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  swlf_in_if.sink                         in_i,
  swlf_out_if.source                      out_o,
  input  logic                            cfg_we_i,
  input  logic [swlf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [swlf_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  logic [swlf_pkg::SYNC_WORD_W-1:0] sync_word_q;
  logic [swlf_pkg::BPU_W-1:0]       bpu_q;

  logic           s0_valid_q;
  logic           s0_bit_q;
  logic           out_valid_q;
  logic           out_data_q;
  logic           out_end_q;
  logic           step;
  swlf_pkg::res_t res;

  assign step       = s0_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s0_valid_q || step;

  assign out_o.valid     = out_valid_q;
  assign out_o.data_bit  = out_data_q;
  assign out_o.frame_end = out_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_word_q <= swlf_pkg::SYNC_WORD_RST;
      bpu_q       <= swlf_pkg::BPU_RST;
    end else if (cfg_we_i) begin
      unique case (swlf_pkg::cfg_idx_e'(cfg_idx_i))
        swlf_pkg::CFG_SYNC_WORD:     sync_word_q <= cfg_data_i[swlf_pkg::SYNC_WORD_W-1:0];
        swlf_pkg::CFG_BITS_PER_UNIT: bpu_q <= cfg_data_i[swlf_pkg::BPU_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      s0_valid_q <= 1'b1;
    end else if (step) begin
      s0_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s0_bit_q <= in_i.bit_in;
    end
  end

  swlf_core #(
    .SYNC_BITS   (SYNC_BITS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (step),
    .bit_i           (s0_bit_q),
    .sync_word_i     (sync_word_q),
    .bits_per_unit_i (bpu_q),
    .res_o           (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= res.valid;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res.valid) begin
      out_data_q <= res.data_bit;
      out_end_q  <= res.frame_end;
    end
  end

endmodule

>>> hdl/swlf_checker.sv
// Port level checks of the sync word length framer, bound to the top level.
module swlf_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_data_bit,
  input logic out_frame_end
);

  // A stalled result beat keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data_bit) && $stable(out_frame_end))
    else $error("output beat changed while stalled");

  // A new result follows an accepted input beat through the input and result registers.
  a_out_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result beat without a matching input beat");

  // The input side only stalls behind a stalled output beat.
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled while output was free");

endmodule

bind sync_word_length_framer_unit swlf_checker u_swlf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid      (in_i.valid),
  .in_ready      (in_i.ready),
  .out_valid     (out_o.valid),
  .out_ready     (out_o.ready),
  .out_data_bit  (out_o.data_bit),
  .out_frame_end (out_o.frame_end)
);
